// File: design/tcbe_pkg.sv
`default_nettype none

package tcbe_pkg;

    // default store size, in cells
    localparam int TEXT_CELLS_DEF = 8192;

    // address arithmetic: columns*row+col plus a run of up to 255 cells
    localparam int BASE_W = 16;
    localparam int OFF_W  = 9;
    localparam int CALC_W = 17;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // operation codes
    localparam logic [2:0] OP_PUT    = 3'd0;
    localparam logic [2:0] OP_REPEAT = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_SETCUR = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_COLUMNS   = 2'd0;
    localparam logic [1:0] CFG_ROWS      = 2'd1;
    localparam logic [1:0] CFG_TEXT_ATTR = 2'd2;

    localparam logic [7:0] COLUMNS_RST   = 8'd80;
    localparam logic [7:0] ROWS_RST      = 8'd25;
    localparam logic [7:0] TEXT_ATTR_RST = 8'd15;

    // control characters
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] char_code;
        logic [7:0] attr_value;
        logic       keep_attr;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] col_end;
        logic [7:0] row_end;
        logic [7:0] count;
    } cmd_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic [7:0] attr_out;
        logic [7:0] cursor_col;
        logic [7:0] cursor_row;
        logic       clipped;
    } res_t;

    // what the front decided a command is
    typedef enum logic [3:0] {
        K_PRINT,
        K_BS,
        K_TAB,
        K_LF,
        K_CR,
        K_NOP,
        K_REP,
        K_CLR,
        K_READ,
        K_SETCUR
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_code;
        logic [7:0] attr_value;
        logic       keep_attr;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] col_end;
        logic [7:0] row_end;
        logic [7:0] count;
    } qent_t;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_MUL,
        ST_PUT,
        ST_REP,
        ST_REP_WR,
        ST_CLR,
        ST_RD,
        ST_RD_WAIT
    } bstate_t;

endpackage

`default_nettype wire

// File: design/tcbe_front.sv
`default_nettype none

module tcbe_front
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire tcbe_pkg::cmd_t cmd,
    output logic                busy,
    input  wire logic           sweeping,
    output logic                q_valid,
    output tcbe_pkg::qent_t     q_data,
    input  wire logic           pop
);

    tcbe_pkg::qent_t                  entry;
    tcbe_pkg::qent_t                  q_mem_reg [tcbe_pkg::QUEUE_DEPTH];
    logic [tcbe_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [tcbe_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [tcbe_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;
    logic                             push;
    logic                             do_pop;

    // classify
    always_comb
    begin
        entry.char_code  = cmd.char_code;
        entry.attr_value = cmd.attr_value;
        entry.keep_attr  = cmd.keep_attr;
        entry.col        = cmd.col;
        entry.row        = cmd.row;
        entry.col_end    = cmd.col_end;
        entry.row_end    = cmd.row_end;
        entry.count      = cmd.count;
        priority if (cmd.operation == tcbe_pkg::OP_PUT)
        begin
            priority if (cmd.char_code == tcbe_pkg::CH_BS)
                entry.kind = tcbe_pkg::K_BS;
            else if (cmd.char_code == tcbe_pkg::CH_TAB)
                entry.kind = tcbe_pkg::K_TAB;
            else if (cmd.char_code == tcbe_pkg::CH_LF)
                entry.kind = tcbe_pkg::K_LF;
            else if (cmd.char_code == tcbe_pkg::CH_CR)
                entry.kind = tcbe_pkg::K_CR;
            else if (cmd.char_code == tcbe_pkg::CH_BEL)
                entry.kind = tcbe_pkg::K_NOP;
            else
                entry.kind = tcbe_pkg::K_PRINT;
        end
        else if (cmd.operation == tcbe_pkg::OP_REPEAT)
            entry.kind = tcbe_pkg::K_REP;
        else if (cmd.operation == tcbe_pkg::OP_CLEAR)
            entry.kind = tcbe_pkg::K_CLR;
        else if (cmd.operation == tcbe_pkg::OP_READ)
            entry.kind = tcbe_pkg::K_READ;
        else if (cmd.operation == tcbe_pkg::OP_SETCUR)
            entry.kind = tcbe_pkg::K_SETCUR;
        else
            entry.kind = tcbe_pkg::K_NOP;
    end

    assign busy    = sweeping || (cnt_reg == tcbe_pkg::QCNT_W'(tcbe_pkg::QUEUE_DEPTH));
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != '0);
    assign do_pop  = pop && q_valid;
    assign q_data  = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == tcbe_pkg::QPTR_W'(tcbe_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == tcbe_pkg::QPTR_W'(tcbe_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= entry;
    end

endmodule

`default_nettype wire

// File: design/tcbe_back.sv
`default_nettype none

module tcbe_back
#(
    parameter int TEXT_CELLS = tcbe_pkg::TEXT_CELLS_DEF
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire tcbe_pkg::qent_t q_data,
    output logic                 pop,
    input  wire logic [7:0]      columns,
    input  wire logic [7:0]      text_attr,
    output logic                 sweeping,
    output logic                 done,
    output tcbe_pkg::res_t       result
);

    localparam int AW = $clog2(TEXT_CELLS);

    logic [15:0] mem [TEXT_CELLS];

    tcbe_pkg::bstate_t              state_reg, state_next;
    tcbe_pkg::qent_t                cmd_reg, cmd_next;
    logic [tcbe_pkg::BASE_W-1:0]    base_reg, base_next;
    logic [tcbe_pkg::OFF_W-1:0]     off_reg, off_next;
    logic [7:0]                     y_reg, y_next;
    logic [7:0]                     cnt_reg, cnt_next;
    logic                           clip_reg, clip_next;
    logic [7:0]                     ccol_reg, ccol_next;
    logic [7:0]                     crow_reg, crow_next;
    logic [AW-1:0]                  sweep_reg, sweep_next;
    logic                           done_reg;
    tcbe_pkg::res_t                 res_reg;
    logic [15:0]                    rdata_reg;

    logic [tcbe_pkg::CALC_W-1:0]    cur_addr;
    logic                           in_range;
    logic [AW-1:0]                  mem_idx;
    logic [AW-1:0]                  mem_waddr;
    logic                           mem_we, mem_re;
    logic [15:0]                    mem_wdata;
    logic [7:0]                     row_sel;
    logic                           rep_none, clr_none, last_rep, clr_row_end, clr_last;
    logic                           fin, fin_clip;
    logic [7:0]                     fin_char, fin_attr;

    assign cur_addr = tcbe_pkg::CALC_W'(base_reg) + tcbe_pkg::CALC_W'(off_reg);
    assign in_range = cur_addr < tcbe_pkg::CALC_W'(TEXT_CELLS);
    assign mem_idx  = cur_addr[AW-1:0];

    assign row_sel  = (cmd_reg.kind == tcbe_pkg::K_PRINT || cmd_reg.kind == tcbe_pkg::K_BS ||
                       cmd_reg.kind == tcbe_pkg::K_READ) ? crow_reg : cmd_reg.row;
    assign rep_none    = (cmd_reg.count == 8'd0);
    assign clr_none    = (cmd_reg.row > cmd_reg.row_end) || (cmd_reg.col > cmd_reg.col_end);
    assign last_rep    = (cnt_reg == 8'd1);
    assign clr_row_end = (off_reg[7:0] == cmd_reg.col_end);
    assign clr_last    = clr_row_end && (y_reg == cmd_reg.row_end);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcbe_pkg::ST_SWEEP:
                if (sweep_reg == AW'(TEXT_CELLS - 1))
                    state_next = tcbe_pkg::ST_IDLE;
            tcbe_pkg::ST_IDLE:
                if (q_valid)
                    state_next = tcbe_pkg::ST_MUL;
            tcbe_pkg::ST_MUL:
                unique case (cmd_reg.kind)
                    tcbe_pkg::K_PRINT,
                    tcbe_pkg::K_BS:     state_next = tcbe_pkg::ST_PUT;
                    tcbe_pkg::K_REP:    state_next = rep_none ? tcbe_pkg::ST_IDLE
                                                              : tcbe_pkg::ST_REP;
                    tcbe_pkg::K_CLR:    state_next = clr_none ? tcbe_pkg::ST_IDLE
                                                              : tcbe_pkg::ST_CLR;
                    tcbe_pkg::K_READ:   state_next = tcbe_pkg::ST_RD;
                    tcbe_pkg::K_TAB,
                    tcbe_pkg::K_LF,
                    tcbe_pkg::K_CR,
                    tcbe_pkg::K_NOP,
                    tcbe_pkg::K_SETCUR: state_next = tcbe_pkg::ST_IDLE;
                    default:            state_next = tcbe_pkg::ST_IDLE;
                endcase
            tcbe_pkg::ST_PUT:
                state_next = tcbe_pkg::ST_IDLE;
            tcbe_pkg::ST_REP:
                priority if (cmd_reg.keep_attr && in_range)
                    state_next = tcbe_pkg::ST_REP_WR;
                else if (last_rep)
                    state_next = tcbe_pkg::ST_IDLE;
                else
                    state_next = tcbe_pkg::ST_REP;
            tcbe_pkg::ST_REP_WR:
                state_next = last_rep ? tcbe_pkg::ST_IDLE : tcbe_pkg::ST_REP;
            tcbe_pkg::ST_CLR:
                if (clr_last)
                    state_next = tcbe_pkg::ST_IDLE;
            tcbe_pkg::ST_RD:
                state_next = in_range ? tcbe_pkg::ST_RD_WAIT : tcbe_pkg::ST_IDLE;
            tcbe_pkg::ST_RD_WAIT:
                state_next = tcbe_pkg::ST_IDLE;
            default:
                state_next = tcbe_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pop        = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_wdata  = '0;
        mem_waddr  = mem_idx;
        fin        = 1'b0;
        fin_clip   = 1'b0;
        fin_char   = '0;
        fin_attr   = '0;
        cmd_next   = cmd_reg;
        base_next  = base_reg;
        off_next   = off_reg;
        y_next     = y_reg;
        cnt_next   = cnt_reg;
        clip_next  = clip_reg;
        ccol_next  = ccol_reg;
        crow_next  = crow_reg;
        sweep_next = sweep_reg;
        unique case (state_reg)
            tcbe_pkg::ST_SWEEP:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                sweep_next = sweep_reg + 1'b1;
            end
            tcbe_pkg::ST_IDLE:
            begin
                pop = q_valid;
                if (q_valid)
                    cmd_next = q_data;
            end
            tcbe_pkg::ST_MUL:
            begin
                base_next = tcbe_pkg::BASE_W'(columns) * tcbe_pkg::BASE_W'(row_sel);
                off_next  = (cmd_reg.kind == tcbe_pkg::K_REP || cmd_reg.kind == tcbe_pkg::K_CLR) ?
                            tcbe_pkg::OFF_W'(cmd_reg.col) : tcbe_pkg::OFF_W'(ccol_reg);
                y_next    = cmd_reg.row;
                cnt_next  = cmd_reg.count;
                clip_next = 1'b0;
                unique case (cmd_reg.kind)
                    tcbe_pkg::K_TAB:
                    begin
                        fin       = 1'b1;
                        ccol_next = (ccol_reg >= 8'd248) ? 8'hFF : {ccol_reg[7:3] + 5'd1, 3'b000};
                    end
                    tcbe_pkg::K_LF:
                    begin
                        fin       = 1'b1;
                        ccol_next = '0;
                        crow_next = (crow_reg == 8'hFF) ? 8'hFF : crow_reg + 8'd1;
                    end
                    tcbe_pkg::K_CR:
                    begin
                        fin       = 1'b1;
                        ccol_next = '0;
                    end
                    tcbe_pkg::K_SETCUR:
                    begin
                        fin       = 1'b1;
                        ccol_next = cmd_reg.col;
                        crow_next = cmd_reg.row;
                    end
                    tcbe_pkg::K_NOP:    fin = 1'b1;
                    tcbe_pkg::K_REP:    fin = rep_none;
                    tcbe_pkg::K_CLR:    fin = clr_none;
                    tcbe_pkg::K_PRINT,
                    tcbe_pkg::K_BS,
                    tcbe_pkg::K_READ:   fin = 1'b0;
                    default:            fin = 1'b1;
                endcase
            end
            tcbe_pkg::ST_PUT:
            begin
                mem_we    = in_range;
                mem_wdata = {text_attr,
                             (cmd_reg.kind == tcbe_pkg::K_BS) ? tcbe_pkg::CH_SPACE
                                                              : cmd_reg.char_code};
                fin       = 1'b1;
                fin_clip  = !in_range;
                if (cmd_reg.kind == tcbe_pkg::K_BS)
                    ccol_next = (ccol_reg == 8'd0) ? 8'd0 : ccol_reg - 8'd1;
                else
                    ccol_next = (ccol_reg == 8'hFF) ? 8'hFF : ccol_reg + 8'd1;
            end
            tcbe_pkg::ST_REP:
            begin
                if (cmd_reg.keep_attr && in_range)
                    mem_re = 1'b1;
                else
                begin
                    mem_we    = in_range;
                    mem_wdata = {cmd_reg.attr_value, cmd_reg.char_code};
                    clip_next = clip_reg | !in_range;
                    cnt_next  = cnt_reg - 8'd1;
                    off_next  = off_reg + 1'b1;
                    fin       = last_rep;
                    fin_clip  = clip_reg | !in_range;
                end
            end
            tcbe_pkg::ST_REP_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {rdata_reg[15:8], cmd_reg.char_code};
                cnt_next  = cnt_reg - 8'd1;
                off_next  = off_reg + 1'b1;
                fin       = last_rep;
                fin_clip  = clip_reg;
            end
            tcbe_pkg::ST_CLR:
            begin
                mem_we    = in_range;
                mem_wdata = {cmd_reg.attr_value, tcbe_pkg::CH_SPACE};
                clip_next = clip_reg | !in_range;
                fin       = clr_last;
                fin_clip  = clip_reg | !in_range;
                if (clr_row_end)
                begin
                    if (!clr_last)
                    begin
                        y_next    = y_reg + 8'd1;
                        off_next  = tcbe_pkg::OFF_W'(cmd_reg.col);
                        base_next = base_reg + tcbe_pkg::BASE_W'(columns);
                    end
                end
                else
                    off_next = off_reg + 1'b1;
            end
            tcbe_pkg::ST_RD:
            begin
                mem_re   = in_range;
                fin      = !in_range;
                fin_clip = !in_range;
            end
            tcbe_pkg::ST_RD_WAIT:
            begin
                fin      = 1'b1;
                fin_char = rdata_reg[7:0];
                fin_attr = rdata_reg[15:8];
            end
            default:
                fin = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcbe_pkg::ST_SWEEP;
            sweep_reg <= '0;
            ccol_reg  <= '0;
            crow_reg  <= '0;
            done_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            ccol_reg  <= ccol_next;
            crow_reg  <= crow_next;
            done_reg  <= fin;
            if (fin)
                res_reg <= '{char_out: fin_char, attr_out: fin_attr, cursor_col: ccol_next,
                             cursor_row: crow_next, clipped: fin_clip};
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        base_reg <= base_next;
        off_reg  <= off_next;
        y_reg    <= y_next;
        cnt_reg  <= cnt_next;
        clip_reg <= clip_next;
    end

    // cell memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_idx];
    end

    assign sweeping = (state_reg == tcbe_pkg::ST_SWEEP);
    assign done     = done_reg;
    assign result   = res_reg;

endmodule

`default_nettype wire

// File: design/text_cell_buffer_engine_unit.sv
`default_nettype none

// The front queues each accepted beat; the back end pops it when idle, forms the cell
// address, then puts, reads, repeats or clears. Cursor-only commands end at the address
// step; a read outside memory ends unread. Repeated write visits each cell (a read, then a
// write per in-memory cell with keep_attr), clear each rectangle cell. The 2-beat queue
// takes start while the back end works, until full. Results cannot be stalled. Reset
// (rst_n, async low): cursor to 0,0, registers 80/25/15, busy while TEXT_CELLS cells clear.

module text_cell_buffer_engine_unit
#(
    parameter int TEXT_CELLS = tcbe_pkg::TEXT_CELLS_DEF
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,

    // command channel: a beat is taken when start is high and busy low
    input  wire logic           start,
    output logic                busy,
    input  wire tcbe_pkg::cmd_t cmd,

    // result: one cycle per beat, marked by done
    output logic                done,
    output tcbe_pkg::res_t      result,

    // configuration write channel
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [7:0]     cfg_data
);

    logic             sweeping;
    logic             q_valid;
    tcbe_pkg::qent_t  q_data;
    logic             pop;

    logic [7:0]       columns_reg, columns_next;
    logic [7:0]       rows_reg, rows_next;
    logic [7:0]       text_attr_reg, text_attr_next;
    logic             cfg_we;

    // config registers; rows is kept for readback-style completeness only
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        columns_next   = columns_reg;
        rows_next      = rows_reg;
        text_attr_next = text_attr_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                tcbe_pkg::CFG_COLUMNS:   columns_next   = cfg_data;
                tcbe_pkg::CFG_ROWS:      rows_next      = cfg_data;
                tcbe_pkg::CFG_TEXT_ATTR: text_attr_next = cfg_data;
                default:                 columns_next   = columns_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg   <= tcbe_pkg::COLUMNS_RST;
            rows_reg      <= tcbe_pkg::ROWS_RST;
            text_attr_reg <= tcbe_pkg::TEXT_ATTR_RST;
        end
        else
        begin
            columns_reg   <= columns_next;
            rows_reg      <= rows_next;
            text_attr_reg <= text_attr_next;
        end
    end

    // front: takes beats, decodes teletype controls, queues work
    tcbe_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .busy     (busy),
        .sweeping (sweeping),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .pop      (pop)
    );

    // back: owns cursor and cell memory, runs one command at a time
    tcbe_back
    #(
        .TEXT_CELLS (TEXT_CELLS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .columns   (columns_reg),
        .text_attr (text_attr_reg),
        .sweeping  (sweeping),
        .done      (done),
        .result    (result)
    );

`ifndef SYNTHESIS
    // no result can come out while memory is still being cleared
    a_no_done_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sweeping |-> !done)
        else $error("result strobe during clearing pass");

    // every command returns to idle, so strobes never run back to back
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for two cycles");

    // result payload only moves together with a strobe
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> $stable(result))
        else $error("result changed without done");
`endif

endmodule

`default_nettype wire
